// ----- rtl/banked_ram_window_decoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the banked RAM window decoder
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BANKED_RAM_WINDOW_DECODER_CORE_ASSERT_SVH
`define BANKED_RAM_WINDOW_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define BRWD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BRWD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/brwd_pkg.sv -----
// ----------------------------------------------------------------------------
// brwd_pkg
// Types, constants and the bank gather function of the window decoder.
// ----------------------------------------------------------------------------
package brwd_pkg;

   localparam int BANKS_PER_CHIP = 32;
   localparam int RAM_BANK_W     = $clog2(BANKS_PER_CHIP);
   localparam int BANK_W         = RAM_BANK_W + 1;

   localparam logic [15:0] ADDR_CONTROL = 16'hD303;
   localparam logic [15:0] ADDR_BANK    = 16'hD301;
   localparam logic [1:0]  WIN_TAG      = 2'b01;   // address[15:14] of 0x4000-0x7FFF
   localparam logic [7:0]  NOP_BYTE     = 8'hEA;
   localparam logic [7:0]  BANK_PORT_RESET = 8'hFF;
   localparam int          CTRL_WIN_BIT = 2;

   typedef enum logic [2:0] {
      MODE_128K   = 3'd0,
      MODE_192K   = 3'd1,
      MODE_320K_A = 3'd2,
      MODE_320K_B = 3'd3,
      MODE_576K   = 3'd4,
      MODE_1088K  = 3'd5,
      MODE_OFF_A  = 3'd6,
      MODE_OFF_B  = 3'd7
   } mode_type;

   typedef struct packed {
      logic [15:0] address;
      logic        is_read;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]            read_data;
      logic                  drive_bus;
      logic                  internal_ram_off;
      logic                  ram_enable;
      logic                  ram_write;
      logic                  ram_chip;
      logic [RAM_BANK_W-1:0] ram_bank;
      logic [13:0]           window_offset;
   } rsp_type;

   function automatic logic [BANK_W-1:0] gather_bank(logic [7:0] p, mode_type mode);
      logic [BANK_W-1:0] bank;
      bank = '0;
      case (mode)
         MODE_128K:   bank = {4'b0, p[3:2]};
         MODE_192K:   bank = {3'b0, p[6], p[3:2]};
         MODE_320K_A: bank = {2'b0, p[6:5], p[3:2]};
         MODE_320K_B: bank = {2'b0, p[7:6], p[3:2]};
         MODE_576K:   bank = {1'b0, p[6:5], p[3:1]};
         default:     bank = {p[7:5], p[3:1]};
      endcase
      return bank;
   endfunction

endpackage

// ----- rtl/brwd_input_stage.sv -----
// ----------------------------------------------------------------------------
// brwd_input_stage
// Input register of the decoder; holds one bus cycle until decode takes it.
// ----------------------------------------------------------------------------
module brwd_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  brwd_pkg::req_type req_item,
   output logic              s1_valid,
   input  logic              s1_take,
   output brwd_pkg::req_type s1_item
);

   logic              valid_ff, valid_in;
   brwd_pkg::req_type item_ff;
   logic              load;

   assign load      = req_valid && !req_stall;
   assign req_stall = valid_ff && !s1_take;
   assign valid_in  = load || (valid_ff && !s1_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;

endmodule

// ----- rtl/brwd_port_regs.sv -----
// ----------------------------------------------------------------------------
// brwd_port_regs
// Emulated bank port and port control registers, mode register and the
// window decode of one bus cycle.
// ----------------------------------------------------------------------------
module brwd_port_regs (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_write_data,
   input  brwd_pkg::req_type  s1_item,
   input  logic               s1_fire,
   output brwd_pkg::rsp_type  dec_item
);

   brwd_pkg::mode_type mode_ff;
   logic [7:0]         bank_port_ff, bank_port_in;
   logic [7:0]         port_control_ff, port_control_in;

   logic                        hit_ctrl, hit_bank, in_win;
   logic [brwd_pkg::BANK_W-1:0] bank;

   assign hit_ctrl = (s1_item.address == brwd_pkg::ADDR_CONTROL);
   assign hit_bank = (s1_item.address == brwd_pkg::ADDR_BANK);
   assign in_win   = (s1_item.address[15:14] == brwd_pkg::WIN_TAG)
                     && port_control_ff[brwd_pkg::CTRL_WIN_BIT];
   assign bank     = brwd_pkg::gather_bank(bank_port_ff, mode_ff);

   always_comb begin
      bank_port_in    = bank_port_ff;
      port_control_in = port_control_ff;
      dec_item        = '0;
      if (hit_ctrl || hit_bank) begin
         if (s1_item.is_read) begin
            dec_item.read_data = hit_ctrl ? port_control_ff : bank_port_ff;
            dec_item.drive_bus = 1'b1;
         end else if (hit_ctrl) begin
            port_control_in = s1_item.write_data;
         end else begin
            bank_port_in = s1_item.write_data;
         end
      end else if (in_win) begin
         dec_item.internal_ram_off = 1'b1;
         if (mode_ff == brwd_pkg::MODE_OFF_A || mode_ff == brwd_pkg::MODE_OFF_B) begin
            // no expansion: reads see a NOP byte, writes are dropped
            if (s1_item.is_read) begin
               dec_item.read_data = brwd_pkg::NOP_BYTE;
               dec_item.drive_bus = 1'b1;
            end
         end else begin
            dec_item.ram_enable    = 1'b1;
            dec_item.ram_write     = !s1_item.is_read;
            dec_item.ram_chip      = bank[brwd_pkg::BANK_W-1];
            dec_item.ram_bank      = bank[brwd_pkg::RAM_BANK_W-1:0];
            dec_item.window_offset = s1_item.address[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= brwd_pkg::MODE_128K;
         bank_port_ff    <= brwd_pkg::BANK_PORT_RESET;
         port_control_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= brwd_pkg::mode_type'(csr_write_data);
         end
         if (s1_fire) begin
            bank_port_ff    <= bank_port_in;
            port_control_ff <= port_control_in;
         end
      end
   end

endmodule

// ----- rtl/brwd_result_stage.sv -----
// ----------------------------------------------------------------------------
// brwd_result_stage
// Result register; loads a decoded item whenever it is empty or being taken.
// ----------------------------------------------------------------------------
module brwd_result_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              s1_valid,
   input  brwd_pkg::rsp_type dec_item,
   output logic              s2_load,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output brwd_pkg::rsp_type rsp_item
);

   logic              valid_ff, valid_in;
   brwd_pkg::rsp_type item_ff;

   assign s2_load  = !valid_ff || !rsp_stall;
   assign valid_in = s2_load ? s1_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid) begin
         item_ff <= dec_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ----- rtl/banked_ram_window_decoder_core.sv -----
// ----------------------------------------------------------------------------
// banked_ram_window_decoder_core
// Host bus cycle decoder for a two-chip banked RAM expansion.
// ----------------------------------------------------------------------------
// Each bus cycle item passes an input register, one decode step and a result
// register, in that order, and one item is taken every cycle while rsp_stall
// stays low. The registers at 0xD301 (bank port, resets to 0xFF) and 0xD303
// (port control) are read and written by the decode step in item order.
// Window cycles (0x4000-0x7FFF with control bit 2 set) turn internal RAM off
// and, in modes 0-5, address one of two external chips; in modes 6-7 reads
// return 0xEA. csr_write_data sets the mode and should be written only while
// no item is in flight.
// ----------------------------------------------------------------------------
module banked_ram_window_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_address,
   input  logic        req_is_read,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_drive_bus,
   output logic        rsp_internal_ram_off,
   output logic        rsp_ram_enable,
   output logic        rsp_ram_write,
   output logic        rsp_ram_chip,
   output logic [brwd_pkg::RAM_BANK_W-1:0] rsp_ram_bank,
   output logic [13:0] rsp_window_offset
);

   brwd_pkg::req_type req_item, s1_item;
   brwd_pkg::rsp_type dec_item, rsp_item;
   logic              s1_valid, s2_load, s1_fire;

   assign req_item.address    = req_address;
   assign req_item.is_read    = req_is_read;
   assign req_item.write_data = req_write_data;

   assign s1_fire = s1_valid && s2_load;

   brwd_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .s1_valid  (s1_valid),
      .s1_take   (s2_load),
      .s1_item   (s1_item)
   );

   brwd_port_regs u_port_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .s1_item          (s1_item),
      .s1_fire          (s1_fire),
      .dec_item         (dec_item)
   );

   brwd_result_stage u_result_stage (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .dec_item  (dec_item),
      .s2_load   (s2_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_read_data        = rsp_item.read_data;
   assign rsp_drive_bus        = rsp_item.drive_bus;
   assign rsp_internal_ram_off = rsp_item.internal_ram_off;
   assign rsp_ram_enable       = rsp_item.ram_enable;
   assign rsp_ram_write        = rsp_item.ram_write;
   assign rsp_ram_chip         = rsp_item.ram_chip;
   assign rsp_ram_bank         = rsp_item.ram_bank;
   assign rsp_window_offset    = rsp_item.window_offset;

endmodule

// ----- rtl/brwd_checker.sv -----
// ----------------------------------------------------------------------------
// brwd_checker
// Port-level checks of the window decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "banked_ram_window_decoder_core_assert.svh"

module brwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_drive_bus,
   input logic        rsp_internal_ram_off,
   input logic        rsp_ram_enable,
   input logic        rsp_ram_write,
   input logic        rsp_ram_chip,
   input logic [brwd_pkg::RAM_BANK_W-1:0] rsp_ram_bank,
   input logic [13:0] rsp_window_offset
);

   // a stalled result keeps its item
   `BRWD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data) && $stable(rsp_ram_bank) && $stable(rsp_window_offset), "stalled result changed")

   // an external chip access always shuts internal RAM off
   `BRWD_ASSERT_NOW(a_ram_ioff, rsp_valid && rsp_ram_enable, rsp_internal_ram_off, "chip selected with internal RAM on")

   // chip fields stay quiet without a chip select
   `BRWD_ASSERT_NOW(a_ram_idle, rsp_valid && !rsp_ram_enable, !rsp_ram_write && !rsp_ram_chip && rsp_ram_bank == '0 && rsp_window_offset == '0, "chip fields set without select")

   // the block never drives the bus and a chip in the same item
   `BRWD_ASSERT_NOW(a_bus_excl, rsp_valid && rsp_drive_bus, !rsp_ram_enable && !rsp_ram_write, "bus drive with chip access")

endmodule

bind banked_ram_window_decoder_core brwd_checker u_checker (.*);
